>>> src/synth_parameter_converter_assert.svh
// Assertion helpers for the parameter converter.
`ifndef SYNTH_PARAMETER_CONVERTER_ASSERT_SVH
`define SYNTH_PARAMETER_CONVERTER_ASSERT_SVH

// same-cycle implication
`define SPC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spc: assertion failed");

// next-cycle implication
`define SPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spc: assertion failed");

`endif

>>> src/spc_pkg.sv
package spc_pkg;

   typedef enum logic [3:0] {
      ACT_DELAY        = 4'd0,
      ACT_ATTACK_HOLD  = 4'd1,
      ACT_SUSTAIN      = 4'd2,
      ACT_DECAY        = 4'd3,
      ACT_CUTOFF       = 4'd4,
      ACT_Q            = 4'd5,
      ACT_PITCH        = 4'd6,
      ACT_CUTOFF_SHIFT = 4'd7,
      ACT_TREMOLO      = 4'd8,
      ACT_FREQ         = 4'd9,
      ACT_PAN          = 4'd10,
      ACT_SEND         = 4'd11,
      ACT_ATTEN        = 4'd12
   } spc_action_type;

   typedef enum logic [2:0] {
      DIV_1,
      DIV_12,
      DIV_15,
      DIV_24,
      DIV_29,
      DIV_75,
      DIV_150,
      DIV_1000
   } spc_div_type;

   localparam int NUM_W       = 30;  // signed numerator / quotient
   localparam int MAG_W       = 29;  // magnitude inside the divider
   localparam int RECIP_SHIFT = 29;
   localparam int RECIP_W     = 30;
   localparam int DVAL_W      = 10;
   localparam int FRAC_W      = 16;  // fraction bits of the exp2 mantissa
   localparam int DIV_LATENCY = 4;

   typedef logic signed [NUM_W-1:0] spc_num_type;
   typedef logic [MAG_W-1:0]        spc_mag_type;
   typedef logic [RECIP_W-1:0]      spc_recip_type;
   typedef logic [DVAL_W-1:0]       spc_dval_type;

   typedef struct packed {
      spc_action_type act;
      logic           early_a;    // lane A result known up front
      logic [7:0]     early_val;
      logic           branch;     // upper segment of attack/decay curve
      logic           early_b;    // hold saturates
   } spc_ctl_type;

   function automatic spc_dval_type div_value(input spc_div_type sel);
      spc_dval_type v;
      case (sel)
         DIV_1:    v = spc_dval_type'(1);
         DIV_12:   v = spc_dval_type'(12);
         DIV_15:   v = spc_dval_type'(15);
         DIV_24:   v = spc_dval_type'(24);
         DIV_29:   v = spc_dval_type'(29);
         DIV_75:   v = spc_dval_type'(75);
         DIV_150:  v = spc_dval_type'(150);
         DIV_1000: v = spc_dval_type'(1000);
         default:  v = spc_dval_type'(1);
      endcase
      return v;
   endfunction

   // floor(2^RECIP_SHIFT / d)
   function automatic spc_recip_type div_recip(input spc_div_type sel);
      spc_recip_type v;
      case (sel)
         DIV_1:    v = spc_recip_type'((64'd1 << RECIP_SHIFT) / 64'd1);
         DIV_12:   v = spc_recip_type'((64'd1 << RECIP_SHIFT) / 64'd12);
         DIV_15:   v = spc_recip_type'((64'd1 << RECIP_SHIFT) / 64'd15);
         DIV_24:   v = spc_recip_type'((64'd1 << RECIP_SHIFT) / 64'd24);
         DIV_29:   v = spc_recip_type'((64'd1 << RECIP_SHIFT) / 64'd29);
         DIV_75:   v = spc_recip_type'((64'd1 << RECIP_SHIFT) / 64'd75);
         DIV_150:  v = spc_recip_type'((64'd1 << RECIP_SHIFT) / 64'd150);
         DIV_1000: v = spc_recip_type'((64'd1 << RECIP_SHIFT) / 64'd1000);
         default:  v = spc_recip_type'((64'd1 << RECIP_SHIFT) / 64'd1);
      endcase
      return v;
   endfunction

endpackage

>>> src/spc_if.sv
interface spc_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         action;
   logic signed [15:0] value_a;
   logic signed [15:0] value_b;

   modport source (output valid, action, value_a, value_b, input ready);
   modport sink (input valid, action, value_a, value_b, output ready);
endinterface

interface spc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] register_value;

   modport source (output valid, register_value, input ready);
   modport sink (input valid, register_value, output ready);
endinterface

>>> src/synth_parameter_converter.sv
// Synthesizer parameter converter.
// req_ch carries one item per handshake: action selects the conversion,
// value_a is the generator amount (attack time for attack/hold) and value_b
// the hold time or, for cutoff shift, the octave span. rsp_ch returns one
// register_value per item, in order: 16 bits for delay and attack/hold,
// otherwise an 8-bit field in bits 7..0 (signed fields as two's complement).
// Unused action codes give 0.
// Pipeline stages: operand decode and constant multiply, four divider
// stages, output clamp register. While results are taken, throughput is
// one item per cycle; the divide by the conversion constant is a pipelined
// reciprocal multiply with a remainder fix, so nothing iterates.
// When rsp_ch.ready is low with a result waiting, the whole pipeline holds
// and req_ch.ready drops; no item is lost or repeated, and an idle output
// register lets new items keep flowing in.
// Reset (synchronous, active high) clears all valid bits; data registers
// are not reset, and no setup is needed before the first item.
`include "synth_parameter_converter_assert.svh"

module synth_parameter_converter (
   input logic       clock,
   input logic       reset,
   spc_req_if.sink   req_ch,
   spc_rsp_if.source rsp_ch
);

   logic                 advance;
   logic                 s1_valid;
   spc_pkg::spc_ctl_type s1_ctl;
   spc_pkg::spc_num_type s1_num_a;
   spc_pkg::spc_num_type s1_num_b;
   spc_pkg::spc_div_type s1_dsel_a;
   spc_pkg::spc_num_type quo_a;
   spc_pkg::spc_num_type quo_b;
   logic                 out_valid;
   logic [15:0]          out_value;

   logic [spc_pkg::DIV_LATENCY-1:0] div_vld_in;
   logic [spc_pkg::DIV_LATENCY-1:0] div_vld_ff;
   spc_pkg::spc_ctl_type            div_ctl_ff [spc_pkg::DIV_LATENCY];

   // the output register frees up when empty or taken this cycle
   assign advance      = !out_valid || rsp_ch.ready;
   assign req_ch.ready = advance;

   spc_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_ch.valid),
      .in_action  (spc_pkg::spc_action_type'(req_ch.action)),
      .in_value_a (req_ch.value_a),
      .in_value_b (req_ch.value_b),
      .out_valid  (s1_valid),
      .out_ctl    (s1_ctl),
      .out_num_a  (s1_num_a),
      .out_num_b  (s1_num_b),
      .out_dsel_a (s1_dsel_a)
   );

   spc_cdiv u_div_a (
      .clock   (clock),
      .advance (advance),
      .num     (s1_num_a),
      .dsel    (s1_dsel_a),
      .quo     (quo_a)
   );

   // hold time, only used by attack/hold
   spc_cdiv u_div_b (
      .clock   (clock),
      .advance (advance),
      .num     (s1_num_b),
      .dsel    (spc_pkg::DIV_75),
      .quo     (quo_b)
   );

   assign div_vld_in = {div_vld_ff[spc_pkg::DIV_LATENCY-2:0], s1_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff <= '0;
      end else if (advance) begin
         div_vld_ff <= div_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_ctl_ff[0] <= s1_ctl;
         for (int i = 1; i < spc_pkg::DIV_LATENCY; i++) begin
            div_ctl_ff[i] <= div_ctl_ff[i-1];
         end
      end
   end

   spc_post u_post (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (div_vld_ff[spc_pkg::DIV_LATENCY-1]),
      .in_ctl    (div_ctl_ff[spc_pkg::DIV_LATENCY-1]),
      .qa        (quo_a),
      .qb        (quo_b),
      .out_valid (out_valid),
      .out_value (out_value)
   );

   assign rsp_ch.valid          = out_valid;
   assign rsp_ch.register_value = out_value;

   `SPC_ASSERT_NEXT(accept_enters_pipe, clock, reset, req_ch.valid && req_ch.ready, s1_valid)
   `SPC_ASSERT_NEXT(stall_freezes_pipe, clock, reset, !advance, $stable(div_vld_ff) && $stable(s1_valid))
   `SPC_ASSERT_NEXT(last_stage_reaches_out, clock, reset, advance, out_valid == $past(div_vld_ff[spc_pkg::DIV_LATENCY-1]))
   `SPC_ASSERT_IMPLIES(stall_blocks_input, clock, reset, out_valid && !rsp_ch.ready, !req_ch.ready)

endmodule

>>> src/spc_prep.sv
module spc_prep (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  spc_pkg::spc_action_type in_action,
   input  logic signed [15:0]     in_value_a,
   input  logic signed [15:0]     in_value_b,
   output logic                   out_valid,
   output spc_pkg::spc_ctl_type   out_ctl,
   output spc_pkg::spc_num_type   out_num_a,
   output spc_pkg::spc_num_type   out_num_b,
   output spc_pkg::spc_div_type   out_dsel_a
);

   localparam int EXP_SHIFT = 12;  // x*65536/1200 == x*4096/75

   localparam logic signed [17:0] DELAY_BIAS  = 18'sh030E4;
   localparam logic signed [17:0] FREQ_BIAS   = 18'sh023A6;
   localparam logic signed [17:0] HOLD_BIAS   = 18'sd4130;
   localparam logic signed [17:0] ATTACK_BIAS = 18'sd500;
   localparam logic signed [17:0] DECAY_KNEE  = 18'sd1800;
   localparam logic signed [17:0] TIME_BIAS   = 18'sd37;
   localparam logic signed [17:0] CUTOFF_BIAS = 18'sd15;
   localparam logic signed [17:0] ATTEN_BIAS  = 18'sd12;
   localparam logic signed [17:0] PAN_BIAS    = 18'sd500;

   localparam logic signed [15:0] DELAY_FLOOR = -16'sd12000;
   localparam logic signed [15:0] ATTACK_MIN  = 16'sd4300;
   localparam logic signed [15:0] ATTACK_KNEE = -16'sd600;
   localparam logic signed [15:0] DECAY_MIN   = 16'sd1800;
   localparam logic signed [15:0] HOLD_FLOOR  = -16'sd5368;
   localparam logic signed [15:0] FREQ_FLOOR  = -16'sd16000;
   localparam logic signed [15:0] PAN_LIMIT   = 16'sd500;
   localparam logic signed [15:0] SEND_LIMIT  = 16'sd1000;
   localparam logic signed [15:0] LFO_SPAN    = 16'sd3;

   localparam logic [12:0] MUL_UNIT   = 13'd1;
   localparam logic [12:0] MUL_EXP    = 13'(1 << EXP_SHIFT);
   localparam logic [12:0] MUL_CB     = 13'd127;
   localparam logic [12:0] MUL_PITCH  = 13'h1B4F;
   localparam logic [12:0] MUL_LFO    = 13'h0919;
   localparam logic [12:0] MUL_FILTER = 13'h048D;
   localparam logic [12:0] MUL_TREM   = 13'd16;
   localparam logic [12:0] MUL_SEND   = 13'd255;

   logic signed [17:0]   a_ext;
   logic signed [17:0]   b_ext;
   logic signed [17:0]   x_sel;
   logic [12:0]          c_sel;
   logic                 use_shift;
   logic signed [31:0]   prod;
   spc_pkg::spc_ctl_type ctl_in;
   spc_pkg::spc_div_type dsel_in;
   spc_pkg::spc_num_type num_a_in;
   spc_pkg::spc_num_type num_b_in;

   logic                 valid_ff;
   spc_pkg::spc_ctl_type ctl_ff;
   spc_pkg::spc_num_type num_a_ff;
   spc_pkg::spc_num_type num_b_ff;
   spc_pkg::spc_div_type dsel_ff;

   assign a_ext = 18'(in_value_a);
   assign b_ext = 18'(in_value_b);

   always_comb begin
      x_sel             = a_ext;
      c_sel             = MUL_UNIT;
      use_shift         = 1'b0;
      dsel_in           = spc_pkg::DIV_1;
      ctl_in.act        = in_action;
      ctl_in.early_a    = 1'b0;
      ctl_in.early_val  = 8'd0;
      ctl_in.branch     = 1'b0;
      ctl_in.early_b    = in_value_b < HOLD_FLOOR;
      case (in_action)
         spc_pkg::ACT_DELAY: begin
            x_sel          = a_ext + DELAY_BIAS;
            c_sel          = MUL_EXP;
            dsel_in        = spc_pkg::DIV_75;
            ctl_in.early_a = in_value_a <= DELAY_FLOOR;
         end
         spc_pkg::ACT_ATTACK_HOLD: begin
            ctl_in.early_a = in_value_a >= ATTACK_MIN;
            ctl_in.branch  = in_value_a > ATTACK_KNEE;
            if (in_value_a > ATTACK_KNEE) begin
               x_sel   = a_ext + ATTACK_BIAS;
               dsel_in = spc_pkg::DIV_150;
            end else begin
               x_sel   = TIME_BIAS - a_ext;
               dsel_in = spc_pkg::DIV_75;
            end
         end
         spc_pkg::ACT_SUSTAIN: begin
            c_sel   = MUL_CB;
            dsel_in = spc_pkg::DIV_1000;
         end
         spc_pkg::ACT_DECAY: begin
            ctl_in.branch = in_value_a > DECAY_MIN;
            if (in_value_a > DECAY_MIN) begin
               x_sel   = a_ext - DECAY_KNEE;
               dsel_in = spc_pkg::DIV_150;
            end else begin
               x_sel   = TIME_BIAS - a_ext;
               dsel_in = spc_pkg::DIV_75;
            end
         end
         spc_pkg::ACT_CUTOFF: begin
            x_sel   = a_ext + CUTOFF_BIAS;
            dsel_in = spc_pkg::DIV_29;
         end
         spc_pkg::ACT_Q: begin
            dsel_in = spc_pkg::DIV_12;
         end
         spc_pkg::ACT_PITCH: begin
            c_sel     = MUL_PITCH;
            use_shift = 1'b1;
         end
         spc_pkg::ACT_CUTOFF_SHIFT: begin
            c_sel     = (in_value_b == LFO_SPAN) ? MUL_LFO : MUL_FILTER;
            use_shift = 1'b1;
         end
         spc_pkg::ACT_TREMOLO: begin
            // a*128/120 == a*16/15
            c_sel   = MUL_TREM;
            dsel_in = spc_pkg::DIV_15;
         end
         spc_pkg::ACT_FREQ: begin
            x_sel          = a_ext + FREQ_BIAS;
            c_sel          = MUL_EXP;
            dsel_in        = spc_pkg::DIV_75;
            ctl_in.early_a = in_value_a <= FREQ_FLOOR;
         end
         spc_pkg::ACT_PAN: begin
            x_sel   = a_ext + PAN_BIAS;
            c_sel   = MUL_CB;
            dsel_in = spc_pkg::DIV_1000;
            if (in_value_a < -PAN_LIMIT) begin
               ctl_in.early_a   = 1'b1;
               ctl_in.early_val = 8'd0;
            end else if (in_value_a > PAN_LIMIT) begin
               ctl_in.early_a   = 1'b1;
               ctl_in.early_val = 8'd127;
            end
         end
         spc_pkg::ACT_SEND: begin
            c_sel   = MUL_SEND;
            dsel_in = spc_pkg::DIV_1000;
            if (in_value_a < 16'sd0) begin
               ctl_in.early_a   = 1'b1;
               ctl_in.early_val = 8'd0;
            end else if (in_value_a > SEND_LIMIT) begin
               ctl_in.early_a   = 1'b1;
               ctl_in.early_val = 8'd255;
            end
         end
         spc_pkg::ACT_ATTEN: begin
            x_sel   = a_ext + ATTEN_BIAS;
            dsel_in = spc_pkg::DIV_24;
         end
         default: begin
            x_sel = 18'sd0;
            c_sel = 13'd0;
         end
      endcase
   end

   assign prod     = 32'(x_sel) * 32'($signed({1'b0, c_sel}));
   // shifted products are floor(p / 65536), then pass the divider with d = 1
   assign num_a_in = use_shift ? spc_pkg::spc_num_type'(prod >>> 16)
                               : spc_pkg::spc_num_type'(prod);
   assign num_b_in = spc_pkg::spc_num_type'({b_ext + HOLD_BIAS, {EXP_SHIFT{1'b0}}});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff   <= ctl_in;
         num_a_ff <= num_a_in;
         num_b_ff <= num_b_in;
         dsel_ff  <= dsel_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_ctl    = ctl_ff;
   assign out_num_a  = num_a_ff;
   assign out_num_b  = num_b_ff;
   assign out_dsel_a = dsel_ff;

endmodule

>>> src/spc_cdiv.sv
// Signed divide by a small constant, truncating toward zero.
// Reciprocal multiply gives q or q-1; one remainder check fixes it.
module spc_cdiv (
   input  logic                 clock,
   input  logic                 advance,
   input  spc_pkg::spc_num_type num,
   input  spc_pkg::spc_div_type dsel,
   output spc_pkg::spc_num_type quo
);

   localparam int WIDE_W = spc_pkg::MAG_W + spc_pkg::RECIP_W;
   localparam int DPROD_W = spc_pkg::MAG_W + spc_pkg::DVAL_W;

   spc_pkg::spc_mag_type mag_s1_in;
   logic [WIDE_W-1:0]    wide_prod;
   logic [DPROD_W-1:0]   dprod;
   spc_pkg::spc_mag_type rem;
   logic                 bump;
   spc_pkg::spc_mag_type qfix;
   spc_pkg::spc_num_type quo_in;

   logic                 neg_s1_ff, neg_s2_ff, neg_s3_ff;
   spc_pkg::spc_mag_type mag_s1_ff, mag_s2_ff, mag_s3_ff;
   spc_pkg::spc_div_type dsel_s1_ff, dsel_s2_ff, dsel_s3_ff;
   spc_pkg::spc_mag_type q0_s2_ff, q0_s3_ff;
   spc_pkg::spc_mag_type dprod_s3_ff;
   spc_pkg::spc_num_type quo_ff;

   assign mag_s1_in = num[spc_pkg::NUM_W-1] ? spc_pkg::spc_mag_type'(-num)
                                            : spc_pkg::spc_mag_type'(num);

   assign wide_prod = {{spc_pkg::RECIP_W{1'b0}}, mag_s1_ff}
                    * {{spc_pkg::MAG_W{1'b0}}, spc_pkg::div_recip(dsel_s1_ff)};

   assign dprod = {{spc_pkg::DVAL_W{1'b0}}, q0_s2_ff}
                * {{spc_pkg::MAG_W{1'b0}}, spc_pkg::div_value(dsel_s2_ff)};

   assign rem  = mag_s3_ff - dprod_s3_ff;
   assign bump = rem >= spc_pkg::spc_mag_type'(spc_pkg::div_value(dsel_s3_ff));
   assign qfix = q0_s3_ff + spc_pkg::spc_mag_type'(bump);
   assign quo_in = neg_s3_ff ? spc_pkg::spc_num_type'(-$signed({1'b0, qfix}))
                             : spc_pkg::spc_num_type'($signed({1'b0, qfix}));

   always_ff @(posedge clock) begin
      if (advance) begin
         neg_s1_ff   <= num[spc_pkg::NUM_W-1];
         mag_s1_ff   <= mag_s1_in;
         dsel_s1_ff  <= dsel;

         neg_s2_ff   <= neg_s1_ff;
         mag_s2_ff   <= mag_s1_ff;
         dsel_s2_ff  <= dsel_s1_ff;
         q0_s2_ff    <= wide_prod[spc_pkg::RECIP_SHIFT +: spc_pkg::MAG_W];

         neg_s3_ff   <= neg_s2_ff;
         mag_s3_ff   <= mag_s2_ff;
         dsel_s3_ff  <= dsel_s2_ff;
         q0_s3_ff    <= q0_s2_ff;
         dprod_s3_ff <= dprod[spc_pkg::MAG_W-1:0];

         quo_ff      <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

>>> src/spc_post.sv
module spc_post (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  spc_pkg::spc_ctl_type in_ctl,
   input  spc_pkg::spc_num_type qa,
   input  spc_pkg::spc_num_type qb,
   output logic                 out_valid,
   output logic [15:0]          out_value
);

   localparam int POW_W = spc_pkg::FRAC_W + 2;

   // mantissa 1.f shifted by the integer exponent; saturates above 16
   function automatic logic [POW_W-1:0] pow2_fixed(input spc_pkg::spc_num_type q);
      logic signed [spc_pkg::NUM_W-spc_pkg::FRAC_W-1:0] ex;
      logic [spc_pkg::FRAC_W:0]                         mant;
      logic [4:0]                                       sh;
      logic [POW_W-1:0]                                 r;
      ex   = q[spc_pkg::NUM_W-1:spc_pkg::FRAC_W];
      mant = {1'b1, q[spc_pkg::FRAC_W-1:0]};
      sh   = 5'd0;
      if (ex < 0) begin
         r = '0;
      end else if (ex > spc_pkg::FRAC_W) begin
         r = POW_W'(1) << (spc_pkg::FRAC_W + 1);
      end else begin
         sh = 5'(spc_pkg::FRAC_W - ex);
         r  = {1'b0, mant >> sh};
      end
      return r;
   endfunction

   logic [POW_W-1:0] pa;
   logic [POW_W-1:0] pb;
   logic [7:0]       att;
   logic [7:0]       hold;
   logic [20:0]      atten_prod;
   logic [15:0]      value_in;

   logic             valid_ff;
   logic [15:0]      value_ff;

   assign pa = pow2_fixed(qa);
   assign pb = pow2_fixed(qb);
   // floor(8t/3) as 8t*683 >> 11, exact for the t that reach here
   assign atten_prod = 21'({qa[6:0], 3'b000}) * 21'd683;

   always_comb begin
      if (in_ctl.early_a) begin
         att = 8'd1;
      end else if (in_ctl.branch) begin
         att = 8'({1'b1, ~qa[2:0]} >> qa[4:3]);
      end else if (qa > 30'sd119) begin
         att = 8'd127;
      end else begin
         att = qa[7:0] + 8'd8;
      end

      if (in_ctl.early_b) begin
         hold = 8'd127;
      end else if (pb >= POW_W'(127)) begin
         hold = 8'd0;
      end else begin
         hold = 8'd127 - pb[7:0];
      end

      value_in = 16'd0;
      case (in_ctl.act)
         spc_pkg::ACT_DELAY: begin
            if (in_ctl.early_a || pa > POW_W'(17'h10000)) begin
               value_in = 16'h8000;
            end else begin
               value_in = 16'h8000 - pa[15:0];
            end
         end
         spc_pkg::ACT_ATTACK_HOLD: begin
            value_in = {hold, att};
         end
         spc_pkg::ACT_SUSTAIN: begin
            if (qa > 30'sd127) begin
               value_in = 16'd0;
            end else if (qa < 30'sd0) begin
               value_in = 16'd127;
            end else begin
               value_in = {8'd0, 8'd127 - qa[7:0]};
            end
         end
         spc_pkg::ACT_DECAY: begin
            if (in_ctl.branch) begin
               if (qa >= 30'sd32) begin
                  value_in = 16'd1;
               end else begin
                  value_in = {8'd0, 8'({1'b1, ~qa[2:0]} >> qa[4:3])};
               end
            end else if (qa > 30'sd88) begin
               value_in = 16'd127;
            end else begin
               value_in = {8'd0, qa[7:0] + 8'd39};
            end
         end
         spc_pkg::ACT_CUTOFF: begin
            if (qa < 30'sd153) begin
               value_in = 16'd0;
            end else if (qa > 30'sd408) begin
               value_in = 16'd255;
            end else begin
               value_in = {8'd0, 8'(qa[8:0] - 9'd153)};
            end
         end
         spc_pkg::ACT_Q: begin
            if (qa < 30'sd0) begin
               value_in = 16'd0;
            end else if (qa > 30'sd15) begin
               value_in = 16'd15;
            end else begin
               value_in = {12'd0, qa[3:0]};
            end
         end
         spc_pkg::ACT_PITCH, spc_pkg::ACT_CUTOFF_SHIFT, spc_pkg::ACT_TREMOLO: begin
            if (qa < -30'sd128) begin
               value_in = 16'h0080;
            end else if (qa > 30'sd127) begin
               value_in = 16'h007F;
            end else begin
               value_in = {8'd0, qa[7:0]};
            end
         end
         spc_pkg::ACT_FREQ: begin
            if (in_ctl.early_a) begin
               value_in = 16'd0;
            end else if (pa >= POW_W'(255)) begin
               value_in = 16'd255;
            end else begin
               value_in = {8'd0, pa[7:0]};
            end
         end
         spc_pkg::ACT_PAN, spc_pkg::ACT_SEND: begin
            value_in = {8'd0, in_ctl.early_a ? in_ctl.early_val : qa[7:0]};
         end
         spc_pkg::ACT_ATTEN: begin
            if (qa <= 30'sd0) begin
               value_in = 16'd0;
            end else if (qa >= 30'sd96) begin
               value_in = 16'd255;
            end else begin
               value_in = {8'd0, atten_prod[18:11]};
            end
         end
         default: begin
            value_in = 16'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         value_ff <= value_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;

endmodule

>>> bench/synth_parameter_converter_checker.sv
module synth_parameter_converter_checker (
   input  logic        clock,
   input  logic        reset,
   spc_req_if          req_ch,
   spc_rsp_if          rsp_ch,
   output int unsigned fail_count,
   output int unsigned pending,
   output int unsigned compared
);

   localparam int          MAX_REPORTS = 10;
   localparam logic [15:0] LFO_SPAN    = 16'sd3;  // octave span that picks the LFO scale

   typedef struct {
      logic [3:0]         act;
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic [15:0]        field;
   } conv_entry_type;

   conv_entry_type field_q[$];
   int unsigned    fails;
   int unsigned    results;

   function automatic longint clamp_range(input longint v, input longint lo,
                                          input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint sat_s8(input longint v);
      return clamp_range(v, -128, 127) & 255;
   endfunction

   // 2^(x/1200) as an integer: x/1200 in 16.16 fixed point, mantissa 1.f shifted down by 16 minus the exponent
   function automatic longint exp2_cents(input longint x);
      longint q;
      longint e;
      q = (x * 65536) / 1200;
      e = q >>> 16;
      if (e < 0)
         return 0;
      if (e > 16)
         return 131072;
      return (65536 | (q & 65535)) >> (16 - e);
   endfunction

   function automatic logic [15:0] convert_parameter(input logic [3:0] act,
                                                     input logic signed [15:0] va,
                                                     input logic signed [15:0] vb);
      longint a, b, r, k, m, t, h;
      a = longint'(va);
      b = longint'(vb);
      r = 0;
      case (act)
         spc_pkg::ACT_DELAY: begin
            if (a <= -12000) begin
               r = 32768;
            end else begin
               t = 32768 - exp2_cents(a + 12516);  // 0x30E4
               if (t < -32768)
                  t = -32768;
               r = t & 65535;
            end
         end
         spc_pkg::ACT_ATTACK_HOLD: begin
            if (a >= 4300) begin
               t = 1;
            end else if (a > -600) begin
               k = (a + 500) / 150;
               m = ((~k) & 7) | 8;
               m = m >> ((k >>> 3) & 3);
               t = (m < 1) ? 1 : m;
            end else begin
               t = (37 - a) / 75 + 8;
               if (t > 127)
                  t = 127;
            end
            if (b < -5368) begin
               h = 127;
            end else begin
               h = 127 - exp2_cents(b + 4130);
               if (h < 0)
                  h = 0;
            end
            r = t | (h << 8);
         end
         spc_pkg::ACT_SUSTAIN: r = clamp_range(127 - (a * 127) / 1000, 0, 127);
         spc_pkg::ACT_DECAY: begin
            if (a > 1800) begin
               k = (a - 1800) / 150;
               m = ((k ^ 7) & 7) | 8;
               m = ((k >>> 3) >= 4) ? 0 : (m >> (k >>> 3));
               r = (m < 1) ? 1 : m;
            end else begin
               t = (37 - a) / 75 + 39;
               r = (t > 127) ? 127 : t;
            end
         end
         spc_pkg::ACT_CUTOFF: r = clamp_range((a + 15) / 29 - 153, 0, 255);
         spc_pkg::ACT_Q:      r = clamp_range(a / 12, 0, 15);
         spc_pkg::ACT_PITCH:  r = sat_s8((a * 6991) >>> 16);  // 0x1B4F
         spc_pkg::ACT_CUTOFF_SHIFT: begin
            k = (vb == LFO_SPAN) ? 2329 : 1165;  // 0x0919 : 0x048D
            r = sat_s8((a * k) >>> 16);
         end
         spc_pkg::ACT_TREMOLO: r = sat_s8((a * 128) / 120);
         spc_pkg::ACT_FREQ: begin
            if (a <= -16000)
               r = 0;
            else
               r = clamp_range(exp2_cents(a + 9126), 0, 255);  // 0x23A6
         end
         spc_pkg::ACT_PAN: begin
            if (a < -500)
               r = 0;
            else if (a > 500)
               r = 127;
            else
               r = (a + 500) * 127 / 1000;
         end
         spc_pkg::ACT_SEND: begin
            if (a < 0)
               r = 0;
            else if (a > 1000)
               r = 255;
            else
               r = a * 255 / 1000;
         end
         spc_pkg::ACT_ATTEN: r = clamp_range((((a + 12) / 24) * 8) / 3, 0, 255);
         default:            r = 0;
      endcase
      return r[15:0];
   endfunction

   always @(posedge clock) begin
      conv_entry_type head;
      if (reset) begin
         field_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (field_q.size() == 0) begin
               fails++;
               if (fails <= MAX_REPORTS)
                  $display("checker: unexpected result 0x%04h with nothing outstanding",
                           rsp_ch.register_value);
            end else begin
               head = field_q.pop_front();
               results++;
               if (rsp_ch.register_value !== head.field) begin
                  fails++;
                  if (fails <= MAX_REPORTS)
                     $display("checker: action %0d a %0d b %0d: expected 0x%04h, got 0x%04h",
                              head.act, head.a, head.b, head.field, rsp_ch.register_value);
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            field_q.push_back('{req_ch.action, req_ch.value_a, req_ch.value_b,
                                convert_parameter(req_ch.action, req_ch.value_a,
                                                  req_ch.value_b)});
      end
      fail_count <= fails;
      pending    <= field_q.size();
      compared   <= results;
   end

endmodule

>>> bench/synth_parameter_converter_tb.sv
module synth_parameter_converter_tb;

   localparam int          RANDOM_ITEMS  = 850;
   localparam int          DRAIN_CYCLES  = 24;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam logic [3:0]  ACT_UNUSED_LO = 4'(spc_pkg::ACT_ATTEN) + 4'd1;
   localparam logic [3:0]  ACT_CODE_MAX  = 4'hF;
   localparam logic [15:0] LFO_SPAN      = 16'sd3;

   logic clock;
   logic reset;

   spc_req_if req_ch();
   spc_rsp_if rsp_ch();

   int unsigned fail_count;
   int unsigned pending;
   int unsigned compared;
   int          cycle_count;
   int          req_quiet;
   int          rsp_quiet;
   int          sent_items;
   int          unused_items;

   synth_parameter_converter dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   synth_parameter_converter_checker convert_check (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending),
      .compared   (compared)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("synth_parameter_converter_tb: done, errors");
         $finish;
      end
   end

   // random wait with occasional runs of back-to-back items
   function automatic int draw_wait(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         quiet_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   function automatic logic signed [15:0] pick_amount(input int lo, input int hi);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 16'($urandom);
         9: begin
            case ($urandom_range(0, 4))
               0:       return 16'sh8000;
               1:       return 16'sh7FFF;
               2:       return 16'sd0;
               3:       return -16'sd1;
               default: return 16'sd1;
            endcase
         end
         default: return 16'(lo + int'($urandom_range(0, hi - lo)));
      endcase
   endfunction

   task automatic send_item(input logic [3:0] act, input logic signed [15:0] a,
                            input logic signed [15:0] b);
      int gap;
      gap = draw_wait(req_quiet);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.action  <= act;
      req_ch.value_a <= a;
      req_ch.value_b <= b;
      do @(posedge clock); while (!req_ch.ready);
      sent_items++;
      if (act >= ACT_UNUSED_LO)
         unused_items++;
   endtask

   // result side back-pressure
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_wait(rsp_quiet);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      logic [3:0]         act;
      logic signed [15:0] a;
      logic signed [15:0] b;
      int                 lo;
      int                 hi;

      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.action  = 4'(spc_pkg::ACT_DELAY);
      req_ch.value_a = 16'sd0;
      req_ch.value_b = 16'sd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // field extremes and the saturating corners of each conversion
      send_item(spc_pkg::ACT_DELAY, -32768, 0);
      send_item(spc_pkg::ACT_DELAY, 32767, -1);
      send_item(spc_pkg::ACT_DELAY, -11999, 0);
      send_item(spc_pkg::ACT_ATTACK_HOLD, -32768, 32767);
      send_item(spc_pkg::ACT_ATTACK_HOLD, 32767, -32768);
      send_item(spc_pkg::ACT_ATTACK_HOLD, -599, -5368);
      send_item(spc_pkg::ACT_ATTACK_HOLD, 4299, -5000);
      send_item(spc_pkg::ACT_SUSTAIN, -32768, 32767);
      send_item(spc_pkg::ACT_SUSTAIN, 32767, 0);
      send_item(spc_pkg::ACT_DECAY, -32768, 0);
      send_item(spc_pkg::ACT_DECAY, 32767, 0);
      send_item(spc_pkg::ACT_DECAY, 1801, 0);
      send_item(spc_pkg::ACT_CUTOFF, 32767, 0);
      send_item(spc_pkg::ACT_Q, 32767, 0);
      send_item(spc_pkg::ACT_PITCH, -32768, 0);
      send_item(spc_pkg::ACT_PITCH, 32767, 0);
      send_item(spc_pkg::ACT_CUTOFF_SHIFT, 32767, LFO_SPAN);
      send_item(spc_pkg::ACT_CUTOFF_SHIFT, -32768, -32768);
      send_item(spc_pkg::ACT_TREMOLO, -32768, 32767);
      send_item(spc_pkg::ACT_FREQ, -12000, 0);
      send_item(spc_pkg::ACT_FREQ, 32767, 0);
      send_item(spc_pkg::ACT_PAN, 501, 0);
      send_item(spc_pkg::ACT_SEND, 1001, 0);
      send_item(spc_pkg::ACT_ATTEN, 32767, 0);
      send_item(ACT_UNUSED_LO, 12345, -1);
      send_item(ACT_CODE_MAX, -1, -1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 19) == 0)
            act = 4'($urandom_range(ACT_UNUSED_LO, ACT_CODE_MAX));
         else
            act = 4'($urandom_range(0, spc_pkg::ACT_ATTEN));
         // windows around where each conversion leaves saturation
         case (act)
            spc_pkg::ACT_DELAY:        begin lo = -12600; hi = 9000;  end
            spc_pkg::ACT_ATTACK_HOLD:  begin lo = -6000;  hi = 4500;  end
            spc_pkg::ACT_SUSTAIN:      begin lo = -200;   hi = 1200;  end
            spc_pkg::ACT_DECAY:        begin lo = -7000;  hi = 7000;  end
            spc_pkg::ACT_CUTOFF:       begin lo = 4300;   hi = 12000; end
            spc_pkg::ACT_Q:            begin lo = -30;    hi = 220;   end
            spc_pkg::ACT_PITCH:        begin lo = -2000;  hi = 2000;  end
            spc_pkg::ACT_CUTOFF_SHIFT: begin lo = -8000;  hi = 8000;  end
            spc_pkg::ACT_TREMOLO:      begin lo = -200;   hi = 200;   end
            spc_pkg::ACT_FREQ:         begin lo = -16100; hi = 12000; end
            spc_pkg::ACT_PAN:          begin lo = -600;   hi = 600;   end
            spc_pkg::ACT_SEND:         begin lo = -100;   hi = 1100;  end
            spc_pkg::ACT_ATTEN:        begin lo = -100;   hi = 2500;  end
            default:                   begin lo = -32768; hi = 32767; end
         endcase
         a = pick_amount(lo, hi);
         if (act == spc_pkg::ACT_ATTACK_HOLD)
            b = pick_amount(-6000, 17000);
         else if (act == spc_pkg::ACT_CUTOFF_SHIFT && $urandom_range(0, 2) == 0)
            b = LFO_SPAN;
         else
            b = pick_amount(-8, 8);
         send_item(act, a, b);
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d items over all conversions, %0d with unused action codes",
               sent_items, unused_items);
      $display("compared %0d results under random gaps and back-pressure", compared);
      if (fail_count == 0)
         $display("synth_parameter_converter_tb: done, clean");
      else
         $display("synth_parameter_converter_tb: done, errors");
      $finish;
   end

endmodule

>>> sim.f
+incdir+src
src/spc_pkg.sv
src/spc_if.sv
src/spc_prep.sv
src/spc_cdiv.sv
src/spc_post.sv
src/synth_parameter_converter.sv
bench/synth_parameter_converter_checker.sv
bench/synth_parameter_converter_tb.sv
